>>> rtl/command_line_field_parser_assert.svh
// assertion macros for the command line field parser
// expects clk and rst_n in the scope of the module that uses them
`ifndef COMMAND_LINE_FIELD_PARSER_ASSERT_SVH
`define COMMAND_LINE_FIELD_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLFP_ASSERT(label, prop, msg)
`define CLFP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> rtl/clfp_pkg.sv
// shared constants, types and character classes of the command line field parser
// no dependencies
package clfp_pkg;

    localparam int LINE_CHARS  = 64;
    localparam int FIELD_LIMIT = 8;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_F  = 8'd70;
    localparam logic [7:0] CH_UP_Z  = 8'd90;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_F  = 8'd102;
    localparam logic [7:0] CH_LO_X  = 8'd120;
    localparam logic [7:0] CH_LO_Z  = 8'd122;

    typedef struct packed {
        logic in_ready;
        logic do_backspace;
        logic do_append;
        logic scan_init;
        logic scan_read;
        logic scan_eval;
        logic emit_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_is_bs;
        logic in_is_cr;
        logic in_is_print;
        logic count_zero;
        logic count_fill;
        logic scan_last;
        logic emit_last;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F);
    endfunction

    function automatic logic is_field_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_MINUS;
    endfunction

endpackage

>>> rtl/clfp_if.sv
// valid/ready channels of the command line field parser: characters in, fields out
// no dependencies
interface clfp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface clfp_field_if;
    logic               valid;
    logic               ready;
    logic [2:0]         field_index;
    logic [3:0]         field_count;
    logic               field_is_number;
    logic [5:0]         field_start;
    logic [6:0]         field_length;
    logic signed [31:0] field_value;
    logic               last;

    modport source (
        output valid, output field_index, output field_count, output field_is_number,
        output field_start, output field_length, output field_value, output last,
        input ready
    );
    modport sink (
        input valid, input field_index, input field_count, input field_is_number,
        input field_start, input field_length, input field_value, input last,
        output ready
    );
endinterface

>>> rtl/command_line_field_parser.sv
// top level of the command line field parser: controller plus datapath
// depends on clfp_pkg, clfp_if, clfp_ctrl and clfp_datapath
//
// Characters are taken one per cycle while the parser is idle: printable bytes are appended to
// the line store, backspace or delete drops the last one, other bytes are dropped. A carriage
// return, or the character that fills the store, closes the line. Closing walks the stored
// characters through the single read port of the line memory, reading and then evaluating each
// one, and then loads one field item per cycle into the output register while the output side
// is free, a single empty item when the line holds no field; the input stays stalled until the
// last item is loaded. An earlier item may still wait on the output while new characters are
// taken. No clearing pass follows reset.
module command_line_field_parser #(
    parameter int LINE_CHARS  = clfp_pkg::LINE_CHARS,
    parameter int FIELD_LIMIT = clfp_pkg::FIELD_LIMIT
) (
    input logic          clk,
    input logic          rst_n,
    clfp_char_if.sink    char_in,
    clfp_field_if.source field_out
);

    clfp_pkg::ctrl_cmd_t cmd;
    clfp_pkg::ctrl_sts_t sts;

    clfp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    clfp_datapath #(
        .LINE_CHARS  (LINE_CHARS),
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .field_out (field_out),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> rtl/clfp_datapath.sv
// line store, scan registers, field tables and output register of the field parser
// depends on clfp_pkg and clfp_if
module clfp_datapath #(
    parameter int LINE_CHARS  = clfp_pkg::LINE_CHARS,
    parameter int FIELD_LIMIT = clfp_pkg::FIELD_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    clfp_char_if.sink          char_in,
    clfp_field_if.source       field_out,
    input  clfp_pkg::ctrl_cmd_t cmd,
    output clfp_pkg::ctrl_sts_t sts
);

    localparam int CW  = $clog2(LINE_CHARS);
    localparam int CNW = $clog2(LINE_CHARS + 1);
    localparam int FW  = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;
    localparam int NW  = $clog2(FIELD_LIMIT + 1);

    logic [7:0]     line_mem [LINE_CHARS];
    logic [7:0]     rdata_reg;
    logic [CNW-1:0] count_reg;
    logic [CW-1:0]  idx_reg;
    logic [NW-1:0]  n_reg;
    logic [FW-1:0]  cur_reg;
    logic [FW-1:0]  emit_reg;
    logic           prev_delim_reg;
    logic           track_reg;
    logic           conv_on_reg;
    logic           hex_reg;
    logic           zero_first_reg;
    logic           first_dig_reg;
    logic [31:0]    num_reg;
    logic [CNW-1:0] len_reg;

    logic [CW-1:0]  start_arr [FIELD_LIMIT];
    logic           kind_arr  [FIELD_LIMIT];
    logic [CNW-1:0] len_arr   [FIELD_LIMIT];
    logic [31:0]    num_arr   [FIELD_LIMIT];
    logic           neg_arr   [FIELD_LIMIT];

    logic               out_valid_reg;
    logic [2:0]         out_index_reg;
    logic [3:0]         out_count_reg;
    logic               out_is_num_reg;
    logic [5:0]         out_start_reg;
    logic [6:0]         out_length_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;

    logic [7:0]     ch;
    logic           ch_field;
    logic           ch_letter;
    logic           ch_digit;
    logic           ch_hexl;
    logic [3:0]     digit_val;
    logic [31:0]    num_scaled;
    logic [31:0]    num_step;
    logic           start_new;
    logic           cont;
    logic           room;
    logic [FW-1:0]  nidx;
    logic [CNW-1:0] len_next;
    logic           n_zero;
    logic           emit_last;

    assign ch         = rdata_reg;
    assign ch_field   = clfp_pkg::is_field_char(ch);
    assign ch_letter  = clfp_pkg::is_letter(ch);
    assign ch_digit   = clfp_pkg::is_digit(ch);
    assign ch_hexl    = hex_reg && clfp_pkg::is_hex_letter(ch);
    assign digit_val  = ch_digit ? ch[3:0] : (ch[3:0] + 4'd9);
    assign num_scaled = hex_reg ? {num_reg[27:0], 4'b0000}
                                : ({num_reg[28:0], 3'b000} + {num_reg[30:0], 1'b0});
    assign num_step   = num_scaled + 32'(digit_val);
    assign start_new  = prev_delim_reg && ch_field;
    assign cont       = !prev_delim_reg && ch_field && track_reg;
    assign room       = n_reg < NW'(FIELD_LIMIT);
    assign nidx       = n_reg[FW-1:0];
    assign len_next   = len_reg + CNW'(1);
    assign n_zero     = (n_reg == '0);
    assign emit_last  = n_zero || ((NW'(emit_reg) + NW'(1)) == n_reg);

    assign char_in.ready = cmd.in_ready;

    always_comb
    begin
        sts.in_valid    = char_in.valid;
        sts.in_is_bs    = (char_in.in_char == clfp_pkg::CH_BS)
                          || (char_in.in_char == clfp_pkg::CH_DEL);
        sts.in_is_cr    = (char_in.in_char == clfp_pkg::CH_CR);
        sts.in_is_print = (char_in.in_char >= clfp_pkg::CH_SPACE)
                          && (char_in.in_char <= clfp_pkg::CH_TILDE);
        sts.count_zero  = (count_reg == '0);
        sts.count_fill  = (count_reg == CNW'(LINE_CHARS - 1));
        sts.scan_last   = ((CNW'(idx_reg) + CNW'(1)) == count_reg);
        sts.emit_last   = emit_last;
        sts.out_free    = !out_valid_reg || field_out.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_append)
                count_reg <= count_reg + CNW'(1);
            else if (cmd.do_backspace && count_reg != '0)
                count_reg <= count_reg - CNW'(1);
            else if (cmd.emit_load && emit_last)
                count_reg <= '0;

            if (cmd.scan_init)
                n_reg <= '0;
            else if (cmd.scan_eval && start_new && room)
                n_reg <= n_reg + NW'(1);

            if (cmd.emit_load)
                out_valid_reg <= 1'b1;
            else if (field_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append)
            line_mem[count_reg[CW-1:0]] <= char_in.in_char;
        if (cmd.scan_read)
            rdata_reg <= line_mem[idx_reg];

        if (cmd.scan_init)
        begin
            idx_reg        <= '0;
            prev_delim_reg <= 1'b1;
            track_reg      <= 1'b0;
            emit_reg       <= '0;
        end
        else if (cmd.scan_eval)
        begin
            idx_reg        <= idx_reg + CW'(1);
            prev_delim_reg <= !ch_field;
            if (start_new)
            begin
                track_reg <= room;
                if (room)
                begin
                    cur_reg         <= nidx;
                    len_reg         <= CNW'(1);
                    start_arr[nidx] <= idx_reg;
                    kind_arr[nidx]  <= !ch_letter;
                    len_arr[nidx]   <= CNW'(1);
                    neg_arr[nidx]   <= (ch == clfp_pkg::CH_MINUS);
                    num_reg         <= ch_digit ? 32'(ch[3:0]) : '0;
                    num_arr[nidx]   <= ch_digit ? 32'(ch[3:0]) : '0;
                    conv_on_reg     <= !ch_letter;
                    hex_reg         <= 1'b0;
                    zero_first_reg  <= (ch == clfp_pkg::CH_ZERO);
                    first_dig_reg   <= (ch == clfp_pkg::CH_MINUS);
                end
            end
            else if (cont)
            begin
                len_reg          <= len_next;
                len_arr[cur_reg] <= len_next;
                if (conv_on_reg)
                begin
                    if (ch_digit || ch_hexl)
                    begin
                        num_reg          <= num_step;
                        num_arr[cur_reg] <= num_step;
                        zero_first_reg   <= first_dig_reg && (ch == clfp_pkg::CH_ZERO);
                        first_dig_reg    <= 1'b0;
                    end
                    else if (zero_first_reg && ch == clfp_pkg::CH_LO_X)
                    begin
                        hex_reg        <= 1'b1;
                        zero_first_reg <= 1'b0;
                    end
                    else
                    begin
                        conv_on_reg <= 1'b0;
                    end
                end
            end
        end

        if (cmd.emit_load)
        begin
            emit_reg       <= emit_reg + FW'(1);
            out_index_reg  <= 3'(emit_reg);
            out_count_reg  <= 4'(n_reg);
            out_last_reg   <= emit_last;
            if (n_zero)
            begin
                out_is_num_reg <= 1'b0;
                out_start_reg  <= '0;
                out_length_reg <= '0;
                out_value_reg  <= '0;
            end
            else
            begin
                out_is_num_reg <= kind_arr[emit_reg];
                out_start_reg  <= 6'(start_arr[emit_reg]);
                out_length_reg <= 7'(len_arr[emit_reg]);
                out_value_reg  <= neg_arr[emit_reg] ? (32'sd0 - signed'(num_arr[emit_reg]))
                                                    : signed'(num_arr[emit_reg]);
            end
        end
    end

    assign field_out.valid           = out_valid_reg;
    assign field_out.field_index     = out_index_reg;
    assign field_out.field_count     = out_count_reg;
    assign field_out.field_is_number = out_is_num_reg;
    assign field_out.field_start     = out_start_reg;
    assign field_out.field_length    = out_length_reg;
    assign field_out.field_value     = out_value_reg;
    assign field_out.last            = out_last_reg;

endmodule

>>> rtl/clfp_ctrl.sv
// state machine of the field parser: line editing, scan sequencing, result emission
// depends on clfp_pkg and command_line_field_parser_assert.svh
`include "command_line_field_parser_assert.svh"

module clfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  clfp_pkg::ctrl_sts_t sts,
    output clfp_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    if (sts.in_is_bs)
                    begin
                        cmd.do_backspace = 1'b1;
                    end
                    else if (sts.in_is_cr)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = sts.count_zero ? S_EMIT : S_READ;
                    end
                    else if (sts.in_is_print)
                    begin
                        cmd.do_append = 1'b1;
                        if (sts.count_fill)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = sts.scan_last ? S_EMIT : S_READ;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `CLFP_ASSERT(a_empty_close, (state_reg == S_IDLE && sts.in_valid && sts.in_is_cr && sts.count_zero) |=> (state_reg == S_EMIT), "empty line did not go straight to emission")
    `CLFP_ASSERT(a_full_close, (state_reg == S_IDLE && sts.in_valid && !sts.in_is_bs && !sts.in_is_cr && sts.in_is_print && sts.count_fill) |=> (state_reg == S_READ), "full line did not start a scan")
    `CLFP_ASSERT(a_line_done, (cmd.emit_load && sts.emit_last) |=> (state_reg == S_IDLE && sts.count_zero), "line store not emptied after last item")
    `CLFP_ASSERT_ALWAYS(a_no_overlap, !(cmd.emit_load && cmd.do_append), "character taken while results are loaded")

endmodule

>>> bench/command_line_field_parser_tb.sv
// self-checking bench for command_line_field_parser: characters in, checked field items out
// depends on clfp_pkg, clfp_if and the command_line_field_parser rtl
// a line-splitting predictor tracks the line store and queues the field items each character causes
module command_line_field_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clfp_pkg::*;

    typedef struct packed {
        logic [2:0]  field_index;
        logic [3:0]  field_count;
        logic        field_is_number;
        logic [5:0]  field_start;
        logic [6:0]  field_length;
        logic [31:0] field_value;
        logic        last;
    } field_item_t;

    class line_field_tracker;
        logic [7:0]  text [LINE_CHARS];
        int unsigned used = 0;
        field_item_t pending_fields[$];
        int unsigned mismatches = 0;
        int unsigned chars_taken = 0;
        int unsigned lines_closed = 0;
        int unsigned fields_checked = 0;

        static function bit letter(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        endfunction

        static function bit digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        static function bit word_char(logic [7:0] c);
            return letter(c) || digit(c) || c == CH_MINUS;
        endfunction

        function logic [31:0] to_number(int s, int len);
            logic [31:0] acc;
            logic [31:0] d;
            logic [7:0]  ch;
            int          i;
            bit          neg;
            bit          hex;
            bit          stop;
            acc = '0;
            i = 0;
            neg = 0;
            hex = 0;
            stop = 0;
            if (len > 0 && text[s] == CH_MINUS)
            begin
                neg = 1;
                i = 1;
            end
            if (i + 1 < len && text[s + i] == CH_ZERO && text[s + i + 1] == CH_LO_X)
            begin
                hex = 1;
                i += 2;
            end
            while (i < len && !stop)
            begin
                ch = text[s + i];
                d = '0;
                if (digit(ch))
                    d = ch - CH_ZERO;
                else if (hex && ((ch >= CH_UP_A && ch <= CH_UP_F) ||
                                 (ch >= CH_LO_A && ch <= CH_LO_F)))
                    d = (ch | 8'h20) - CH_LO_A + 10;
                else
                    stop = 1;
                if (!stop)
                begin
                    acc = hex ? {acc[27:0], 4'b0000} + d : acc * 10 + d;
                    i++;
                end
            end
            return neg ? 32'd0 - acc : acc;
        endfunction

        function void split_line();
            int          starts[$];
            bit          kinds[$];
            bit          prev_gap;
            int          n;
            int          len;
            field_item_t r;
            prev_gap = 1;
            for (int i = 0; i < used; i++)
            begin
                if (prev_gap && word_char(text[i]))
                begin
                    starts.push_back(i);
                    kinds.push_back(!letter(text[i]));
                end
                prev_gap = !word_char(text[i]);
                if (starts.size() >= FIELD_LIMIT)
                    break;
            end
            n = starts.size();
            if (n == 0)
            begin
                r = '0;
                r.last = 1'b1;
                pending_fields.push_back(r);
            end
            for (int k = 0; k < n; k++)
            begin
                len = 0;
                while (starts[k] + len < used && word_char(text[starts[k] + len]))
                    len++;
                r.field_index = k[2:0];
                r.field_count = n[3:0];
                r.field_is_number = kinds[k];
                r.field_start = starts[k][5:0];
                r.field_length = len[6:0];
                r.field_value = kinds[k] ? to_number(starts[k], len) : 32'd0;
                r.last = (k + 1 == n);
                pending_fields.push_back(r);
            end
            used = 0;
            lines_closed++;
        endfunction

        function void note_char(logic [7:0] c);
            chars_taken++;
            if (c == CH_BS || c == CH_DEL)
            begin
                if (used > 0)
                    used--;
            end
            else if (c == CH_CR)
                split_line();
            else if (c >= CH_SPACE && c <= CH_TILDE)
            begin
                if (used < LINE_CHARS)
                begin
                    text[used] = c;
                    used++;
                end
                if (used >= LINE_CHARS)
                    split_line();
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_field(field_item_t got);
            field_item_t want;
            if (pending_fields.size() == 0)
            begin
                report_mismatch("unexpected item", got.field_start, 0);
                return;
            end
            want = pending_fields.pop_front();
            fields_checked++;
            if (got.field_index !== want.field_index)
                report_mismatch("field_index", got.field_index, want.field_index);
            if (got.field_count !== want.field_count)
                report_mismatch("field_count", got.field_count, want.field_count);
            if (got.field_is_number !== want.field_is_number)
                report_mismatch("field_is_number", got.field_is_number, want.field_is_number);
            if (got.field_start !== want.field_start)
                report_mismatch("field_start", got.field_start, want.field_start);
            if (got.field_length !== want.field_length)
                report_mismatch("field_length", got.field_length, want.field_length);
            if (got.field_value !== want.field_value)
                report_mismatch("field_value", got.field_value, want.field_value);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        offer = 1'b0;
    logic [7:0]  offer_char = 8'd0;
    logic        take = 1'b0;
    bit          calm = 0;
    int          gap_odds = 3;
    int          stall_left = 0;
    field_item_t seen;

    line_field_tracker tracker = new();

    clfp_char_if  char_bus();
    clfp_field_if field_bus();

    assign char_bus.valid = offer;
    assign char_bus.in_char = offer_char;
    assign field_bus.ready = take;

    command_line_field_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .field_out(field_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check accepted items, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && field_bus.valid && field_bus.ready)
        begin
            seen.field_index = field_bus.field_index;
            seen.field_count = field_bus.field_count;
            seen.field_is_number = field_bus.field_is_number;
            seen.field_start = field_bus.field_start;
            seen.field_length = field_bus.field_length;
            seen.field_value = field_bus.field_value;
            seen.last = field_bus.last;
            tracker.check_field(seen);
        end
        if (!rst_n)
            take <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            take <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            take <= 1'b0;
        end
        else
            take <= 1'b1;
    end

    task automatic send_char(logic [7:0] c);
        int gap;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 16);
            offer <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        offer <= 1'b1;
        offer_char <= c;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        tracker.note_char(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_char(CH_CR);
    endtask

    task automatic wait_for_fields();
        offer <= 1'b0;
        while (tracker.pending_fields.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_word_char(bit letters_only);
        string wordset;
        wordset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789--";
        return wordset[letters_only ? $urandom_range(0, 51) : $urandom_range(0, 63)];
    endfunction

    function automatic logic [7:0] rand_gap_char();
        logic [7:0] c;
        c = CH_SPACE;
        if ($urandom_range(0, 2) == 0)
        begin
            c = 8'($urandom_range(CH_SPACE, CH_TILDE));
            while (line_field_tracker::word_char(c))
                c = 8'($urandom_range(CH_SPACE, CH_TILDE));
        end
        return c;
    endfunction

    task automatic send_rand_field();
        string hexset;
        int    n;
        hexset = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 4))
            0:
            begin
                send_char(rand_word_char(1));
                n = $urandom_range(0, 6);
                repeat (n) send_char(rand_word_char(0));
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    send_char(CH_MINUS);
                n = $urandom_range(1, 11);
                repeat (n) send_char(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
            2:
            begin
                if ($urandom_range(0, 1))
                    send_char(CH_MINUS);
                send_char(CH_ZERO);
                send_char(CH_LO_X);
                n = $urandom_range(0, 9);
                repeat (n) send_char(hexset[$urandom_range(0, 21)]);
                if ($urandom_range(0, 3) == 0)
                    send_char(rand_word_char(0));
            end
            default:
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_char(rand_word_char(0));
            end
        endcase
    endtask

    task automatic send_rand_line();
        int nf;
        nf = $urandom_range(0, 10);
        if ($urandom_range(0, 1))
            send_char(rand_gap_char());
        for (int k = 0; k < nf; k++)
        begin
            send_rand_field();
            if ($urandom_range(0, 7) == 0)
                send_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
            repeat ($urandom_range(1, 2)) send_char(rand_gap_char());
        end
        if ($urandom_range(0, 9) == 0)
            send_char(8'($urandom_range(128, 255)));
        send_char(CH_CR);
    endtask

    initial
    begin
        int random_base;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty lines, backspace on an empty line, ignored bytes
        send_char(CH_CR);
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(8'd1);
        send_char(8'd200);
        send_line(";");
        // numbers: extremes, wrap, hex in both cases, conversion stops
        send_line("12 -7 0XAB 0xdEF");
        send_line("-0x80000000 0xFFFFFFFF - 12ab 0x1g -0x 9-9");
        // more fields than the limit
        send_line("a b c d e f g h i");
        // line editing
        send_text("ab");
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(CH_DEL);
        send_line("1");
        // line closed by a full store with a long wrapping number, then an empty line
        send_text("x -5 0x1F ");
        repeat (LINE_CHARS - 10) send_char(CH_NINE);
        send_char(CH_CR);

        wait_for_fields();

        random_base = tracker.chars_taken;
        while (tracker.chars_taken < random_base + 40)
        begin
            if (tracker.chars_taken >= random_base + 25)
                calm = 1;
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 3;
            case ($urandom_range(0, 11))
                9:       repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(0, 255)));
                10:      repeat (LINE_CHARS + 6) send_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
                default: send_rand_line();
            endcase
        end
        calm = 1;
        send_char(CH_CR);

        wait_for_fields();
        repeat (2 * LINE_CHARS + FIELD_LIMIT + 20) @(posedge clk);

        $display("%0d characters sent, %0d lines closed, %0d field items checked",
                 tracker.chars_taken, tracker.lines_closed, tracker.fields_checked);
        $display("covered empty and full lines, editing, ignored bytes, field limit, numbers");
        if (tracker.mismatches == 0 && tracker.pending_fields.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d field items outstanding", tracker.pending_fields.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
